>>> sv/beacon_frame_builder_crc16_defines.svh
// ----------------------------------------------------------------------------
// Beacon frame builder assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BEACON_FRAME_BUILDER_CRC16_DEFINES_SVH
`define BEACON_FRAME_BUILDER_CRC16_DEFINES_SVH

// same-cycle implication
`define BFB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bfb assertion failed");

// next-cycle implication
`define BFB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bfb assertion failed");

`endif

>>> sv/bfb_pkg.sv
// ----------------------------------------------------------------------------
// Beacon frame builder package
// Frame constants, CRC-16 CCITT byte update, controller state and handshake
// structs shared by the controller and datapath.
// ----------------------------------------------------------------------------
package bfb_pkg;

  localparam int unsigned FrameLen = 16;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CrcSpan  = 14;

  localparam logic [31:0]     Magic    = 32'hCAFEBABE;
  localparam logic [15:0]     SeqReset = 16'hFFFF;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(FrameLen - 1);
  localparam logic [IdxW-1:0] CrcLoIdx = IdxW'(CrcSpan);

  // byte positions in the frame
  localparam logic [IdxW-1:0] IdxMagic0 = 4'd0;
  localparam logic [IdxW-1:0] IdxMagic1 = 4'd1;
  localparam logic [IdxW-1:0] IdxMagic2 = 4'd2;
  localparam logic [IdxW-1:0] IdxMagic3 = 4'd3;
  localparam logic [IdxW-1:0] IdxId7    = 4'd4;
  localparam logic [IdxW-1:0] IdxId6    = 4'd5;
  localparam logic [IdxW-1:0] IdxId5    = 4'd6;
  localparam logic [IdxW-1:0] IdxId4    = 4'd7;
  localparam logic [IdxW-1:0] IdxId3    = 4'd8;
  localparam logic [IdxW-1:0] IdxId2    = 4'd9;
  localparam logic [IdxW-1:0] IdxId1    = 4'd10;
  localparam logic [IdxW-1:0] IdxId0    = 4'd11;
  localparam logic [IdxW-1:0] IdxSeqLo  = 4'd12;
  localparam logic [IdxW-1:0] IdxSeqHi  = 4'd13;
  localparam logic [IdxW-1:0] IdxCrcLo  = 4'd14;
  localparam logic [IdxW-1:0] IdxCrcHi  = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_e;

  typedef struct packed {
    logic start;  // new frame: bump sequence, clear index and CRC
    logic load;   // move next frame byte into the output register
  } bfb_cmd_t;

  typedef struct packed {
    logic slot_free;  // output register can take a byte this cycle
    logic last_idx;   // next byte to load is the final one
  } bfb_sts_t;

  function automatic logic [15:0] crc_update(input logic [15:0] acc,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = {acc[7:0], acc[15:8]};
    c = c ^ {8'h00, data};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

>>> sv/bfb_req_if.sv
// ----------------------------------------------------------------------------
// Beacon request channel
// Valid/ready channel carrying one send request per transaction.
// ----------------------------------------------------------------------------
interface bfb_req_if;
  logic valid;
  logic ready;
  logic send_request;

  modport source (output valid, output send_request, input ready);
  modport sink (input valid, input send_request, output ready);
endinterface

>>> sv/bfb_byte_if.sv
// ----------------------------------------------------------------------------
// Beacon frame byte channel
// Valid/ready channel carrying one frame byte with its position per transaction.
// ----------------------------------------------------------------------------
interface bfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [3:0] byte_index;
  logic       last_byte;

  modport source (output valid, output frame_byte, output byte_index,
                  output last_byte, input ready);
  modport sink (input valid, input frame_byte, input byte_index,
                input last_byte, output ready);
endinterface

>>> sv/bfb_cfg_if.sv
// ----------------------------------------------------------------------------
// Beacon configuration write channel
// Valid/ready channel writing the 64-bit device identifier.
// ----------------------------------------------------------------------------
interface bfb_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] device_id;

  modport source (output valid, output device_id, input ready);
  modport sink (input valid, input device_id, output ready);
endinterface

>>> sv/bfb_ctrl.sv
// ----------------------------------------------------------------------------
// Beacon frame builder controller
// Idle/send sequencer issuing start and byte-load commands to the datapath.
// ----------------------------------------------------------------------------
module bfb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              send_request_i,
  output logic              req_ready_o,
  input  bfb_pkg::bfb_sts_t sts_i,
  output bfb_pkg::bfb_cmd_t cmd_o
);
  import bfb_pkg::*;

  state_e state_q, state_d;
  logic   load;
  logic   frame_done;
  logic   start;

  assign load       = (state_q == ST_SEND) && sts_i.slot_free;
  assign frame_done = load && sts_i.last_idx;
  // next request may enter on the cycle the last byte is loaded
  assign req_ready_o = (state_q == ST_IDLE) || frame_done;
  assign start       = req_valid_i && req_ready_o && send_request_i;

  assign cmd_o.start = start;
  assign cmd_o.load  = load;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SEND;
      end
      ST_SEND: begin
        if (frame_done) state_d = start ? ST_SEND : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/bfb_datapath.sv
// ----------------------------------------------------------------------------
// Beacon frame builder datapath
// Device id, sequence counter, byte counter, running CRC and output register.
// ----------------------------------------------------------------------------
module bfb_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfb_pkg::bfb_cmd_t cmd_i,
  output bfb_pkg::bfb_sts_t sts_o,
  input  logic              cfg_we_i,
  input  logic [63:0]       cfg_device_id_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        frame_byte_o,
  output logic [3:0]        byte_index_o,
  output logic              last_byte_o
);
  import bfb_pkg::*;

  logic [63:0]     device_id_q;
  logic [15:0]     seq_q;
  logic [15:0]     crc_q;
  logic [IdxW-1:0] idx_q;
  logic            out_valid_q;
  logic [7:0]      byte_q;
  logic [IdxW-1:0] byte_idx_q;
  logic            last_q;
  logic [7:0]      next_byte;

  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.last_idx  = (idx_q == LastIdx);

  always_comb begin
    unique case (idx_q)
      IdxMagic0: next_byte = Magic[7:0];
      IdxMagic1: next_byte = Magic[15:8];
      IdxMagic2: next_byte = Magic[23:16];
      IdxMagic3: next_byte = Magic[31:24];
      IdxId7:    next_byte = device_id_q[63:56];
      IdxId6:    next_byte = device_id_q[55:48];
      IdxId5:    next_byte = device_id_q[47:40];
      IdxId4:    next_byte = device_id_q[39:32];
      IdxId3:    next_byte = device_id_q[31:24];
      IdxId2:    next_byte = device_id_q[23:16];
      IdxId1:    next_byte = device_id_q[15:8];
      IdxId0:    next_byte = device_id_q[7:0];
      IdxSeqLo:  next_byte = seq_q[7:0];
      IdxSeqHi:  next_byte = seq_q[15:8];
      IdxCrcLo:  next_byte = crc_q[7:0];
      IdxCrcHi:  next_byte = crc_q[15:8];
      default:   next_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= 64'h0;
      seq_q       <= SeqReset;
      crc_q       <= 16'h0000;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) device_id_q <= cfg_device_id_i;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_q + 1'b1;
        // CRC covers everything ahead of the CRC bytes
        if (idx_q < CrcLoIdx) crc_q <= crc_update(crc_q, next_byte);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // start may coincide with loading the final byte; it wins on idx/crc
      if (cmd_i.start) begin
        seq_q <= seq_q + 16'd1;
        crc_q <= 16'h0000;
        idx_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q     <= next_byte;
      byte_idx_q <= idx_q;
      last_q     <= (idx_q == LastIdx);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign byte_index_o = byte_idx_q;
  assign last_byte_o  = last_q;

endmodule

>>> sv/beacon_frame_builder_crc16.sv
// Start: a taken send request moves the sequencer to its send state, which then
// loads byte 0 to the output register. Rate: one byte per cycle unless stalled;
// the next request is taken in the cycle the last byte enters the output register.
// Output stalls hold the sequencer; a request with send_request low is dropped.
// Reset: async active low; sequence counter to 0xFFFF, device id and CRC to 0.
`include "beacon_frame_builder_crc16_defines.svh"
// ----------------------------------------------------------------------------
// Beacon frame builder with CRC-16 trailer
// Top level: joins the controller and datapath to the request, byte and
// configuration channels.
// ----------------------------------------------------------------------------
module beacon_frame_builder_crc16 (
  input logic        clk_i,
  input logic        rst_ni,
  bfb_req_if.sink    req_i,
  bfb_byte_if.source frame_o,
  bfb_cfg_if.sink    cfg_i
);
  import bfb_pkg::*;

  bfb_cmd_t cmd;
  bfb_sts_t sts;
  logic     cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  bfb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_i.valid),
    .send_request_i (req_i.send_request),
    .req_ready_o    (req_i.ready),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  bfb_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we),
    .cfg_device_id_i (cfg_i.device_id),
    .out_ready_i     (frame_o.ready),
    .out_valid_o     (frame_o.valid),
    .frame_byte_o    (frame_o.frame_byte),
    .byte_index_o    (frame_o.byte_index),
    .last_byte_o     (frame_o.last_byte)
  );

  `BFB_ASSERT_IMP(a_last_on_final, frame_o.valid && frame_o.last_byte, frame_o.byte_index == LastIdx)
  `BFB_ASSERT_NXT(a_load_shows, cmd.load, frame_o.valid)
  `BFB_ASSERT_IMP(a_ready_at_end, cmd.load && sts.last_idx, req_i.ready)

endmodule

>>> tb/beacon_frame_builder_crc16_test.sv
// ----------------------------------------------------------------------------
// Beacon frame builder testbench
// Sends beacon requests with random gaps, writes the device identifier between
// phases and checks every frame byte against a local frame and CRC predictor.
// Output backpressure is random; short back-to-back runs check full rate.
// ----------------------------------------------------------------------------
module beacon_frame_builder_crc16_test;
  import bfb_pkg::*;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [3:0] byte_index;
    logic       last_byte;
  } beacon_byte_t;

  localparam int unsigned SettleCycles = 4;

  logic clk_i;
  logic rst_ni;

  bfb_req_if  req ();
  bfb_byte_if frm ();
  bfb_cfg_if  cfg ();

  beacon_frame_builder_crc16 u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .frame_o (frm),
    .cfg_i   (cfg)
  );

  // predictor state
  logic [63:0]  device_id_reg;
  logic [15:0]  seq_count;
  beacon_byte_t frame_bytes_q[$];
  int unsigned  fail_count;
  bit           no_idle;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // bitwise CRC-16 CCITT, start value 0, no reflection
  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc,
                                                 input logic [7:0]  data);
    logic [15:0] c;
    int          b;
    c = acc ^ {data, 8'h00};
    for (b = 0; b < 8; b++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  task automatic queue_beacon_frame();
    logic [7:0]  fb[FrameLen];
    logic [15:0] crc;
    beacon_byte_t entry;
    int i;
    seq_count = seq_count + 16'd1;
    for (i = 0; i < 4; i++) fb[i] = Magic[8*i +: 8];
    for (i = 0; i < 8; i++) fb[4 + i] = device_id_reg[56 - 8*i +: 8];
    fb[IdxSeqLo] = seq_count[7:0];
    fb[IdxSeqHi] = seq_count[15:8];
    crc = 16'h0000;
    for (i = 0; i < CrcSpan; i++) crc = crc_ccitt_step(crc, fb[i]);
    fb[IdxCrcLo] = crc[7:0];
    fb[IdxCrcHi] = crc[15:8];
    for (i = 0; i < FrameLen; i++) begin
      entry.frame_byte = fb[i];
      entry.byte_index = IdxW'(i);
      entry.last_byte  = (IdxW'(i) == LastIdx);
      frame_bytes_q.push_back(entry);
    end
  endtask

  // one request transaction; valid is left high until the next negedge user
  task automatic send_beacon_req(input logic rq);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap != 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid        = 1'b1;
    req.send_request = rq;
    do @(posedge clk_i); while (!req.ready);
    if (rq) queue_beacon_frame();
  endtask

  task automatic drain_frames();
    @(negedge clk_i);
    req.valid = 1'b0;
    while (frame_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_device_id(input logic [63:0] value);
    drain_frames();
    @(negedge clk_i);
    cfg.valid     = 1'b1;
    cfg.device_id = value;
    do @(posedge clk_i); while (!cfg.ready);
    device_id_reg = value;
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  // output side: random stall per transaction
  initial begin
    int unsigned stall;
    frm.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      @(negedge clk_i);
      if (stall != 0) begin
        frm.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      frm.ready = 1'b1;
      do @(posedge clk_i); while (!(frm.valid && frm.ready));
    end
  end

  always @(posedge clk_i) begin
    beacon_byte_t exp_b;
    if (rst_ni && frm.valid && frm.ready) begin
      if (frame_bytes_q.size() == 0) begin
        $display("%0t: unexpected frame byte %02h index %0d last %0b", $time,
                 frm.frame_byte, frm.byte_index, frm.last_byte);
        fail_count++;
      end else begin
        exp_b = frame_bytes_q.pop_front();
        if (frm.frame_byte !== exp_b.frame_byte) begin
          $display("%0t: frame_byte expected %02h actual %02h", $time,
                   exp_b.frame_byte, frm.frame_byte);
          fail_count++;
        end
        if (frm.byte_index !== exp_b.byte_index) begin
          $display("%0t: byte_index expected %0d actual %0d", $time,
                   exp_b.byte_index, frm.byte_index);
          fail_count++;
        end
        if (frm.last_byte !== exp_b.last_byte) begin
          $display("%0t: last_byte expected %0b actual %0b", $time,
                   exp_b.last_byte, frm.last_byte);
          fail_count++;
        end
      end
    end
  end

  // counter must hold across a dropped request; first frame carries 0
  task automatic test_first_frame();
    send_beacon_req(1'b0);
    send_beacon_req(1'b1);
    send_beacon_req(1'b1);
  endtask

  task automatic test_dropped_requests();
    send_beacon_req(1'b0);
    send_beacon_req(1'b1);
    send_beacon_req(1'b0);
    send_beacon_req(1'b0);
    send_beacon_req(1'b1);
  endtask

  task automatic test_device_id_patterns();
    logic [63:0] ids[6];
    int i;
    ids = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
            64'h8000_0000_0000_0001, 64'h0000_0000_0000_0000};
    for (i = 0; i < 6; i++) begin
      write_device_id(ids[i]);
      send_beacon_req(1'b1);
    end
  endtask

  task automatic test_back_to_back();
    int i;
    write_device_id(64'hFEDC_BA98_7654_3210);
    no_idle = 1'b1;
    for (i = 0; i < 4; i++) send_beacon_req(1'b1);
    drain_frames();
    no_idle = 1'b0;
  endtask

  task automatic test_random_frames();
    int phase;
    int sent;
    for (phase = 0; phase < 6; phase++) begin
      write_device_id({$urandom, $urandom});
      no_idle = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 40) begin
        if ($urandom_range(0, 99) < 15) begin
          send_beacon_req(1'b0);
        end else begin
          send_beacon_req(1'b1);
          sent++;
        end
      end
      drain_frames();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    device_id_reg    = 64'd0;
    seq_count        = SeqReset;
    fail_count       = 0;
    no_idle          = 1'b0;
    rst_ni           = 1'b0;
    req.valid        = 1'b0;
    req.send_request = 1'b0;
    cfg.valid        = 1'b0;
    cfg.device_id    = 64'd0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_first_frame();
    test_dropped_requests();
    test_device_id_patterns();
    test_back_to_back();
    test_random_frames();

    drain_frames();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && frame_bytes_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/bfb_pkg.sv
sv/bfb_req_if.sv
sv/bfb_byte_if.sv
sv/bfb_cfg_if.sv
sv/bfb_ctrl.sv
sv/bfb_datapath.sv
sv/beacon_frame_builder_crc16.sv
tb/beacon_frame_builder_crc16_test.sv
